// File: hw/rtl/hslrgb_pkg.sv
// Shared types, constants and a helper function of the HSL to RGB converter.
`timescale 1ns / 1ps

package hslrgb_pkg;

    localparam int HUE_W   = 13;
    localparam int CH_W    = 8;
    localparam int Q_W     = 9;
    localparam int M_W     = 8;
    localparam int PROD_W  = 16;
    localparam int LBASE_W = 25;
    localparam int F_W     = 10;
    localparam int PF_W    = 27;
    localparam int NUM_W   = 28;
    localparam int SCL_W   = 31;
    localparam int Q_SHIFT = 21;
    localparam int N_CH    = 3;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [HUE_W-1:0] HUE_WRAP = 13'd5760;
    localparam logic [Q_W-1:0]   Q_ONE    = 9'd256;
    localparam logic [Q_W-1:0]   Q_HALF   = 9'd128;
    localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;

    // Hue offsets for red, green and blue in sixteenths of a degree.
    localparam logic [HUE_W-1:0] CH_OFF [N_CH] = '{13'd0, 13'd3840, 13'd1920};

    localparam logic signed [HUE_W:0] K_LO  = 14'sd1440;
    localparam logic signed [HUE_W:0] K_HI  = 14'sd4320;
    localparam logic signed [HUE_W:0] F_MAX = 14'sd480;

    typedef enum logic {
        REG_SAT   = 1'b0,
        REG_LIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PROD_W-1:0]  prod;
        logic [LBASE_W-1:0] lbase;
    } t_cfg;

    // Channel weight, scaled by 480 and clamped to +/-480.
    function automatic logic signed [F_W-1:0] f_weight(input logic [HUE_W-1:0] k);
        logic signed [HUE_W:0] lo;
        logic signed [HUE_W:0] hi;
        logic signed [HUE_W:0] f;
        lo = $signed({1'b0, k}) - K_LO;
        hi = K_HI - $signed({1'b0, k});
        f  = (lo < hi) ? lo : hi;
        if (f > F_MAX) begin
            f = F_MAX;
        end
        if (f < -F_MAX) begin
            f = -F_MAX;
        end
        return f[F_W-1:0];
    endfunction

endpackage

// File: hw/rtl/hslrgb_hue_if.sv
// Request channel that carries one hue.
`timescale 1ns / 1ps

interface hslrgb_hue_if import hslrgb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_sixteenths;

    modport source (output valid, output hue_sixteenths, input ready);
    modport sink   (input valid, input hue_sixteenths, output ready);
endinterface

// File: hw/rtl/hslrgb_rgb_if.sv
// Request channel that carries one RGB color.
`timescale 1ns / 1ps

interface hslrgb_rgb_if import hslrgb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hw/rtl/hslrgb_cfg.sv
// APB register file for saturation and lightness, with derived pipeline terms.
`timescale 1ns / 1ps

module hslrgb_cfg import hslrgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [Q_W-1:0]     r_sat;
    logic [Q_W-1:0]     r_light;
    logic [Q_W-1:0]     n_sat;
    logic [Q_W-1:0]     n_light;
    t_cfg               r_cfg;
    t_cfg               n_cfg;
    t_reg_idx           w_idx;
    logic               w_wr;
    logic [Q_W-1:0]     w_s;
    logic [Q_W-1:0]     w_l;
    logic [Q_W-1:0]     w_lc;
    logic [M_W-1:0]     w_m;
    logic [PROD_W:0]    w_prod;
    logic [LBASE_W:0]   w_lbase;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_sat   = r_sat;
        n_light = r_light;
        prdata  = '0;
        case (w_idx)
            REG_SAT: begin
                prdata = {{(APB_DW-Q_W){1'b0}}, r_sat};
                if (w_wr) begin
                    n_sat = pwdata[Q_W-1:0];
                end
            end
            REG_LIGHT: begin
                prdata = {{(APB_DW-Q_W){1'b0}}, r_light};
                if (w_wr) begin
                    n_light = pwdata[Q_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_comb begin
        w_s     = (r_sat > Q_ONE) ? Q_ONE : r_sat;
        w_l     = (r_light > Q_ONE) ? Q_ONE : r_light;
        w_lc    = (w_l < Q_HALF) ? w_l : (Q_ONE - w_l);
        w_m     = w_lc[M_W-1:0];
        w_prod  = {{(PROD_W+1-Q_W){1'b0}}, w_s} * {{(PROD_W+1-M_W){1'b0}}, w_m};
        // L * 256 * 480 = (L << 17) - (L << 13)
        w_lbase = ({{(LBASE_W+1-Q_W){1'b0}}, w_l} << 17)
                - ({{(LBASE_W+1-Q_W){1'b0}}, w_l} << 13);
        n_cfg.prod  = w_prod[PROD_W-1:0];
        n_cfg.lbase = w_lbase[LBASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat       <= Q_ONE;
            r_light     <= Q_HALF;
            r_cfg.prod  <= 16'd32768;
            r_cfg.lbase <= 25'd15728640;
        end else begin
            r_sat   <= n_sat;
            r_light <= n_light;
            r_cfg   <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/hslrgb_pipe.sv
// Four-stage color pipeline: hue offset, channel weight, product, scale and saturate.
`timescale 1ns / 1ps

module hslrgb_pipe import hslrgb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    hslrgb_hue_if.sink           i_hue,
    hslrgb_rgb_if.source         o_rgb
);

    logic [3:0]                   r_vld;
    logic [3:0]                   n_vld;
    logic [3:0]                   w_go;
    logic [HUE_W-1:0]             r_k   [N_CH];
    logic [HUE_W-1:0]             n_k   [N_CH];
    logic signed [F_W-1:0]        r_f   [N_CH];
    logic signed [F_W-1:0]        n_f   [N_CH];
    logic signed [PF_W-1:0]       r_pf  [N_CH];
    logic signed [PF_W-1:0]       n_pf  [N_CH];
    logic [CH_W-1:0]              r_rgb [N_CH];
    logic [CH_W-1:0]              n_rgb [N_CH];
    logic [HUE_W-1:0]             w_h;
    logic [HUE_W:0]               w_ksum [N_CH];
    logic signed [NUM_W-1:0]      w_num  [N_CH];
    logic [SCL_W-1:0]             w_scl  [N_CH];
    logic [SCL_W-Q_SHIFT-1:0]     w_q    [N_CH];

    assign w_go[3] = !r_vld[3] || o_rgb.ready;
    assign w_go[2] = !r_vld[2] || w_go[3];
    assign w_go[1] = !r_vld[1] || w_go[2];
    assign w_go[0] = !r_vld[0] || w_go[1];

    assign i_hue.ready = w_go[0];

    always_comb begin
        n_vld[0] = w_go[0] ? i_hue.valid : r_vld[0];
        n_vld[1] = w_go[1] ? r_vld[0]    : r_vld[1];
        n_vld[2] = w_go[2] ? r_vld[1]    : r_vld[2];
        n_vld[3] = w_go[3] ? r_vld[2]    : r_vld[3];
    end

    always_comb begin
        w_h = (i_hue.hue_sixteenths >= HUE_WRAP) ? (i_hue.hue_sixteenths - HUE_WRAP)
                                                 : i_hue.hue_sixteenths;
        for (int c = 0; c < N_CH; c++) begin
            w_ksum[c] = {1'b0, w_h} + {1'b0, CH_OFF[c]};
            n_k[c]    = (w_ksum[c] >= {1'b0, HUE_WRAP}) ? w_ksum[c][HUE_W-1:0] - HUE_WRAP
                                                        : w_ksum[c][HUE_W-1:0];
            n_f[c]    = f_weight(r_k[c]);
            n_pf[c]   = $signed({1'b0, i_cfg.prod}) * r_f[c];
            w_num[c]  = $signed({{(NUM_W-LBASE_W){1'b0}}, i_cfg.lbase})
                      - {r_pf[c][PF_W-1], r_pf[c]};
            // num * 255 / (65536 * 480) reduces to num * 17 / 2^21
            w_scl[c]  = ({{(SCL_W-NUM_W+1){1'b0}}, w_num[c][NUM_W-2:0]} << 4)
                      + {{(SCL_W-NUM_W+1){1'b0}}, w_num[c][NUM_W-2:0]};
            w_q[c]    = w_scl[c][SCL_W-1:Q_SHIFT];
            if (w_num[c] <= 0) begin
                n_rgb[c] = '0;
            end else if (w_q[c] > {{(SCL_W-Q_SHIFT-CH_W){1'b0}}, CH_MAX}) begin
                n_rgb[c] = CH_MAX;
            end else begin
                n_rgb[c] = w_q[c][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < N_CH; c++) begin
            if (w_go[0]) begin
                r_k[c] <= n_k[c];
            end
            if (w_go[1]) begin
                r_f[c] <= n_f[c];
            end
            if (w_go[2]) begin
                r_pf[c] <= n_pf[c];
            end
            if (w_go[3]) begin
                r_rgb[c] <= n_rgb[c];
            end
        end
    end

    assign o_rgb.valid = r_vld[3];
    assign o_rgb.red   = r_rgb[0];
    assign o_rgb.green = r_rgb[1];
    assign o_rgb.blue  = r_rgb[2];

endmodule

// File: hw/rtl/hsl_to_rgb_pixel_convert.sv
// Top level of the HSL to RGB pixel converter.
`timescale 1ns / 1ps

// Converts one hue (sixteenths of a degree, wrapped modulo 360 degrees) per clock,
// unless the output stalls, into an 8-bit RGB color using the saturation and
// lightness registers (Q1.8, 256 is 1.0, register 0 at address 0, register 1 at address 4).
// A hue request enters the four-stage color pipeline and its color passes through
// the hue offset, weight, product and output registers; a stalled output holds the pipeline in place.
// Write the registers only while no pixel is in flight.

module hsl_to_rgb_pixel_convert import hslrgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    hslrgb_hue_if.sink        i_hue,
    hslrgb_rgb_if.source      o_rgb
);

    t_cfg w_cfg;

    hslrgb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hslrgb_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_hue   (i_hue),
        .o_rgb   (o_rgb)
    );

endmodule

// File: tb/sv/hslrgb_color_checker.sv
// Color checker: watches the hue and RGB channels, predicts each color and compares.
`timescale 1ns / 1ps

module hslrgb_color_checker import hslrgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    hslrgb_hue_if             i_hue,
    hslrgb_rgb_if             i_rgb,
    output int                o_fail_count,
    output int                o_pending
);

    localparam longint UNIT_K   = 480;
    localparam longint WRAP_K   = 5760;
    localparam longint ONE_Q    = 256;
    localparam longint TOP_LVL  = 255;
    localparam longint RED_OFS  = 0;
    localparam longint GRN_OFS  = 8 * UNIT_K;
    localparam longint BLU_OFS  = 4 * UNIT_K;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    logic [Q_W-1:0] sat_reg;
    logic [Q_W-1:0] light_reg;
    t_color         color_q[$];
    int             mismatches = 0;

    function automatic logic [CH_W-1:0] channel_level(input longint hue, input longint ofs,
                                                      input longint s, input longint l,
                                                      input longint m);
        longint k;
        longint f;
        longint num;
        longint lvl;
        k = (hue + ofs) % WRAP_K;
        f = ((k - 3 * UNIT_K) < (9 * UNIT_K - k)) ? (k - 3 * UNIT_K) : (9 * UNIT_K - k);
        if (f > UNIT_K) begin
            f = UNIT_K;
        end
        if (f < -UNIT_K) begin
            f = -UNIT_K;
        end
        num = l * ONE_Q * UNIT_K - s * m * f;
        if (num <= 0) begin
            return '0;
        end
        lvl = (num * TOP_LVL) / (ONE_Q * ONE_Q * UNIT_K);
        if (lvl > TOP_LVL) begin
            lvl = TOP_LVL;
        end
        return lvl[CH_W-1:0];
    endfunction

    function automatic t_color predict_color(input logic [HUE_W-1:0] hue_raw,
                                             input logic [Q_W-1:0] sat_raw,
                                             input logic [Q_W-1:0] light_raw);
        longint hue;
        longint s;
        longint l;
        longint m;
        t_color c;
        hue = longint'(hue_raw) % WRAP_K;
        s = (longint'(sat_raw) > ONE_Q) ? ONE_Q : longint'(sat_raw);
        l = (longint'(light_raw) > ONE_Q) ? ONE_Q : longint'(light_raw);
        m = (l < ONE_Q - l) ? l : ONE_Q - l;
        c.red   = channel_level(hue, RED_OFS, s, l, m);
        c.green = channel_level(hue, GRN_OFS, s, l, m);
        c.blue  = channel_level(hue, BLU_OFS, s, l, m);
        return c;
    endfunction

    task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_color want;
        if (!i_rst_n) begin
            sat_reg   = Q_ONE;
            light_reg = Q_HALF;
            color_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (t_reg_idx'(paddr[2]) == REG_SAT) begin
                    sat_reg = pwdata[Q_W-1:0];
                end else begin
                    light_reg = pwdata[Q_W-1:0];
                end
            end
            if (i_hue.valid && i_hue.ready) begin
                color_q.push_back(predict_color(i_hue.hue_sixteenths, sat_reg, light_reg));
            end
            if (i_rgb.valid && i_rgb.ready) begin
                if (color_q.size() == 0) begin
                    $error("color returned with no request outstanding");
                    mismatches++;
                end else begin
                    want = color_q.pop_front();
                    check_channel("red", want.red, i_rgb.red);
                    check_channel("green", want.green, i_rgb.green);
                    check_channel("blue", want.blue, i_rgb.blue);
                end
            end
        end
        o_pending    <= color_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/sv/hsl_to_rgb_pixel_convert_tb.sv
// Testbench top: drives hues and register writes into the converter and reports the verdict.
`timescale 1ns / 1ps

module hsl_to_rgb_pixel_convert_tb;
    import hslrgb_pkg::*;

    localparam int N_PHASES   = 10;
    localparam int PLAN_LEN   = 6;
    localparam int RAND_ITEMS = 92;
    localparam int SAT_PLAN [PLAN_LEN]   = '{256, 0, 256, 511, 0, 257};
    localparam int LIGHT_PLAN [PLAN_LEN] = '{128, 0, 256, 511, 256, 64};
    localparam int HUE_DIRECTED [22] = '{0, 5759, 5760, 8191, 480, 960, 1440, 1920, 2400,
                                         2880, 3360, 3840, 4320, 4800, 5280, 1, 479, 481,
                                         7000, 6000, 4096, 2048};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              steady = 1'b0;
    logic              stall_hold = 1'b0;
    int                hue_accepted = 0;
    int                fail_cnt;
    int                pending_cnt;

    hslrgb_hue_if hue_ch ();
    hslrgb_rgb_if rgb_ch ();

    hsl_to_rgb_pixel_convert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_hue   (hue_ch),
        .o_rgb   (rgb_ch)
    );

    hslrgb_color_checker color_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_hue        (hue_ch),
        .i_rgb        (rgb_ch),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // hold off idling on both sides for a stretch of requests
    always @(posedge i_clk) begin
        steady <= (hue_accepted >= 400) && (hue_accepted < 520);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb_ch.ready <= 1'b0;
        end else if (stall_hold) begin
            rgb_ch.ready <= 1'b0;
        end else if (steady) begin
            rgb_ch.ready <= 1'b1;
        end else begin
            rgb_ch.ready <= ($urandom_range(0, 99) >= 11);
        end
    end

    // stall the output long enough to fill the pipeline and back up the input
    initial begin
        wait (hue_accepted >= 600);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (60) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    initial begin
        #5000000;
        $display("[hsl_to_rgb_pixel_convert] ERROR");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [Q_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom();
        word[Q_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_hue(input logic [HUE_W-1:0] hue);
        while (!steady && $urandom_range(0, 99) < 11) begin
            hue_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        hue_ch.valid          <= 1'b1;
        hue_ch.hue_sixteenths <= hue;
        @(posedge i_clk);
        while (!hue_ch.ready) @(posedge i_clk);
        hue_accepted <= hue_accepted + 1;
    endtask

    function automatic logic [HUE_W-1:0] random_hue();
        if ($urandom_range(0, 99) < 15) begin
            return HUE_W'($urandom_range(5760, 8191));
        end
        return HUE_W'($urandom_range(0, 5759));
    endfunction

    task automatic wait_drain();
        repeat (2) @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int sat_val;
        int light_val;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        hue_ch.valid          = 1'b0;
        hue_ch.hue_sixteenths = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                if (ph < PLAN_LEN) begin
                    sat_val   = SAT_PLAN[ph];
                    light_val = LIGHT_PLAN[ph];
                end else begin
                    sat_val   = ($urandom_range(0, 99) < 20) ? $urandom_range(257, 511)
                                                             : $urandom_range(0, 256);
                    light_val = ($urandom_range(0, 99) < 20) ? $urandom_range(257, 511)
                                                             : $urandom_range(0, 256);
                end
                write_reg(REG_SAT, Q_W'(sat_val));
                write_reg(REG_LIGHT, Q_W'(light_val));
            end
            if (ph == 0) begin
                foreach (HUE_DIRECTED[i]) begin
                    push_hue(HUE_W'(HUE_DIRECTED[i]));
                end
            end
            repeat (RAND_ITEMS) push_hue(random_hue());
            hue_ch.valid <= 1'b0;
            wait_drain();
        end

        if (fail_cnt == 0) begin
            $display("[hsl_to_rgb_pixel_convert] OK");
        end else begin
            $display("[hsl_to_rgb_pixel_convert] ERROR");
        end
        $finish;
    end

endmodule
